// ===== rtl/core/m3inv_pkg.sv =====
package m3inv_pkg;

  // Port field widths.
  localparam int unsigned ELEM_IN_W = 16;
  localparam int unsigned ADJ_W     = 33;
  localparam int unsigned DET_W     = 49;
  localparam int unsigned INV_W     = 49;
  localparam int unsigned IDX_W     = 2;

  // Internal arithmetic widths.
  localparam int unsigned PROD_W  = 2 * ELEM_IN_W;
  localparam int unsigned ADJ_MAG_W = ADJ_W - 1;
  localparam int unsigned DEN_W   = DET_W - 1;

  // Packed stream widths.
  localparam int unsigned S_DATA_W = 9 * ELEM_IN_W;
  localparam int unsigned M_FIELDS_W = 2 * IDX_W + ADJ_W + DET_W + INV_W;
  localparam int unsigned M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  // Number of results per matrix and the index of the last one.
  localparam int unsigned N_RES = 9;
  localparam logic [3:0] LAST_IDX = 4'd8;
  localparam logic [IDX_W-1:0] LAST_COL = 2'd2;

  typedef logic signed [ELEM_IN_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ADJ_W-1:0]     adj_t;
  typedef logic signed [DET_W-1:0]     det_t;

  // Per-result data that rides along the divider pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    adj_t             adj;
    det_t             det;
    logic             sing;
    logic             neg;
    logic             last;
  } side_t;

endpackage

// ===== rtl/core/matrix3x3_inverse_adjugate_unit.sv =====
// Channel   | Dir | Payload
// s_axis    | in  | one 3x3 matrix per transaction, nine signed elements
// m_axis    | out | one inverse element per transaction, nine per matrix, tlast on ninth
//
// A matrix is accepted as a whole; its nine results leave one per cycle while m_axis
// is not stalled, so the single result channel sets the sustained matrix rate.
// From acceptance to the first result a matrix passes the sign-extension stage,
// four further front stages (cofactors and determinant), the matrix hold register, one
// operand stage, one restoring divider stage per quotient bit, and the output
// register. Reset clears only valid and busy bits and the result counters.
// A stall on m_axis freezes the divider pipeline; the front stages keep filling.
module matrix3x3_inverse_adjugate_unit
  import m3inv_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (16 bits each)
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_row, out_col, adjugate_value, determinant, inverse_value, zero pad
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // singular
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned SH    = ELEM_IN_W - ELEM_WIDTH;
  localparam int unsigned NUM_W = ADJ_MAG_W + FRAC_BITS;

  // Stage A: sign-extended matrix.
  elem_t m [3][3];
  logic  va;
  // Stage B: the eighteen cofactor products.
  prod_t pb [18];
  elem_t mb0 [3];
  logic  vb;
  // Stage C: cofactors.
  adj_t  cc [3][3];
  elem_t mc0 [3];
  logic  vc;
  // Stage D: first-row expansion terms.
  det_t  td [3];
  adj_t  cd [3][3];
  logic  vd;
  // Stage E: determinant.
  det_t  dete;
  adj_t  ce [3][3];
  logic  ve;

  logic en_a, en_b, en_c, en_d, en_e;
  logic load;
  logic div_adv;

  // Serializer.
  adj_t             adj_buf [N_RES];
  det_t             det_buf;
  logic [3:0]       cnt;
  logic [IDX_W-1:0] row_cnt;
  logic [IDX_W-1:0] col_cnt;
  logic             busy;

  // Divider pipeline, stage 0 is the operand stage.
  logic             dv    [NUM_W+1];
  logic [DEN_W-1:0] drem  [NUM_W+1];
  logic [NUM_W-1:0] dnum  [NUM_W+1];
  logic [DEN_W-1:0] dden  [NUM_W+1];
  side_t            dside [NUM_W+1];

  // Output register.
  logic             out_v;
  side_t            out_side;
  det_t             out_inv;

  // Elastic enables of the front stages.
  assign div_adv = !out_v || m_axis_tready;
  assign load    = ve && (!busy || (div_adv && cnt == LAST_IDX));
  assign en_e    = !ve || load;
  assign en_d    = !vd || en_e;
  assign en_c    = !vc || en_d;
  assign en_b    = !vb || en_c;
  assign en_a    = !va || en_b;
  assign s_axis_tready = en_a;

  // Front valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (en_a) va <= s_axis_tvalid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
      if (en_e) ve <= vd;
    end
  end

  // Stage A: keep the low ELEM_WIDTH bits of each element, sign-extended.
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int k = 0; k < 9; k++) begin
        m[k/3][k%3] <= elem_t'($signed(s_axis_tdata[k*ELEM_IN_W +: ELEM_IN_W] << SH) >>> SH);
      end
    end
  end

  // Stage B: products for all nine 2x2 minors.
  always_ff @(posedge clk) begin
    if (en_b) begin
      pb[0]  <= m[1][1] * m[2][2];
      pb[1]  <= m[1][2] * m[2][1];
      pb[2]  <= m[1][2] * m[2][0];
      pb[3]  <= m[1][0] * m[2][2];
      pb[4]  <= m[1][0] * m[2][1];
      pb[5]  <= m[1][1] * m[2][0];
      pb[6]  <= m[0][2] * m[2][1];
      pb[7]  <= m[0][1] * m[2][2];
      pb[8]  <= m[0][0] * m[2][2];
      pb[9]  <= m[0][2] * m[2][0];
      pb[10] <= m[0][1] * m[2][0];
      pb[11] <= m[0][0] * m[2][1];
      pb[12] <= m[0][1] * m[1][2];
      pb[13] <= m[0][2] * m[1][1];
      pb[14] <= m[0][2] * m[1][0];
      pb[15] <= m[0][0] * m[1][2];
      pb[16] <= m[0][0] * m[1][1];
      pb[17] <= m[0][1] * m[1][0];
      for (int j = 0; j < 3; j++) mb0[j] <= m[0][j];
    end
  end

  // Stage C: cofactors as differences of product pairs.
  always_ff @(posedge clk) begin
    if (en_c) begin
      for (int k = 0; k < 9; k++) begin
        cc[k/3][k%3] <= ADJ_W'(pb[2*k]) - ADJ_W'(pb[2*k+1]);
      end
      for (int j = 0; j < 3; j++) mc0[j] <= mb0[j];
    end
  end

  // Stage D: first-row terms of the determinant, formed at full product width.
  always_ff @(posedge clk) begin
    if (en_d) begin
      for (int j = 0; j < 3; j++) td[j] <= DET_W'(mc0[j]) * DET_W'(cc[0][j]);
      cd <= cc;
    end
  end

  // Stage E: determinant sum.
  always_ff @(posedge clk) begin
    if (en_e) begin
      dete <= td[0] + td[1] + td[2];
      ce   <= cd;
    end
  end

  // Serializer: holds one matrix and feeds one element per cycle while the divider advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cnt     <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (load) begin
      busy    <= 1'b1;
      cnt     <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (busy && div_adv) begin
      if (cnt == LAST_IDX) busy <= 1'b0;
      cnt <= cnt + 4'd1;
      if (col_cnt == LAST_COL) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 2'd1;
      end else begin
        col_cnt <= col_cnt + 2'd1;
      end
    end
  end

  // Adjugate is the transposed cofactor matrix, stored in row-major order.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 9; k++) adj_buf[k] <= ce[k%3][k/3];
      det_buf <= dete;
    end
  end

  // Operand stage: magnitudes and sign of the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (div_adv) begin
      dv[0] <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (div_adv) begin
      dside[0].row  <= row_cnt;
      dside[0].col  <= col_cnt;
      dside[0].adj  <= adj_buf[cnt];
      dside[0].det  <= det_buf;
      dside[0].sing <= (det_buf == '0);
      dside[0].neg  <= adj_buf[cnt][ADJ_W-1] ^ det_buf[DET_W-1];
      dside[0].last <= (cnt == LAST_IDX);
      drem[0]       <= '0;
      dnum[0]       <= NUM_W'(ADJ_MAG_W'(adj_buf[cnt][ADJ_W-1] ? -adj_buf[cnt]
                                                               : adj_buf[cnt])) << FRAC_BITS;
      dden[0]       <= DEN_W'(det_buf[DET_W-1] ? -det_buf : det_buf);
    end
  end

  // Restoring divider: one quotient bit per stage, shifted into the numerator.
  for (genvar s = 1; s <= NUM_W; s++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           qbit;

    always_comb begin
      trial = {drem[s-1], dnum[s-1][NUM_W-1]};
      diff  = trial - {1'b0, dden[s-1]};
      qbit  = !diff[DEN_W];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else if (div_adv) begin
        dv[s] <= dv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (div_adv) begin
        drem[s]  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dnum[s]  <= {dnum[s-1][NUM_W-2:0], qbit};
        dden[s]  <= dden[s-1];
        dside[s] <= dside[s-1];
      end
    end
  end

  // Output register: apply sign, force zero for a singular matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (div_adv) begin
      out_v <= dv[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (div_adv) begin
      out_side <= dside[NUM_W];
      if (dside[NUM_W].sing) begin
        out_inv <= '0;
      end else if (dside[NUM_W].neg) begin
        out_inv <= -det_t'(INV_W'(dnum[NUM_W]));
      end else begin
        out_inv <= det_t'(INV_W'(dnum[NUM_W]));
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = out_side.sing;
  assign m_axis_tlast  = out_side.last;
  assign m_axis_tdata  = M_DATA_W'({out_inv, out_side.det, out_side.adj,
                                    out_side.col, out_side.row});

endmodule
